### src/srx_pkg.sv
package srx_pkg;

    // Top-level sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FILL,
        ST_MIX,
        ST_EMIT
    } state_t;

    // Block-mix unit phases.
    typedef enum logic [2:0] {
        BM_IDLE,
        BM_INIT,
        BM_XOR,
        BM_ROUND,
        BM_ADD,
        BM_WRITE
    } bm_state_t;

    localparam logic CFG_BLOCK_FACTOR = 1'b0;
    localparam logic CFG_COST_LOG2    = 1'b1;

    localparam logic [1:0] RESET_BLOCK_FACTOR = 2'd1;
    localparam logic [3:0] RESET_COST_LOG2    = 4'd10;

    // Start request from the sequencer to the block-mix unit, with the table XOR select.
    typedef struct packed {
        logic start;
        logic xor_table;
    } bm_ctrl_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    // One Salsa20 quarter round on four words.
    function automatic logic [127:0] quarter(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] b1;
        logic [31:0] c1;
        logic [31:0] d1;
        logic [31:0] a1;
        b1 = b ^ rotl(a + d, 7);
        c1 = c ^ rotl(b1 + a, 9);
        d1 = d ^ rotl(c1 + b1, 13);
        a1 = a ^ rotl(d1 + c1, 18);
        quarter = {d1, c1, b1, a1};
    endfunction

    // Column round (row low) or row round (row high) over the 16-word state.
    function automatic logic [511:0] half_round(input logic [511:0] s, input logic row);
        logic [31:0] x [16];
        logic [127:0] q;
        logic [511:0] o;
        for (int i = 0; i < 16; i++) x[i] = s[32*i +: 32];
        if (!row)
        begin
            q = quarter(x[0], x[4], x[8], x[12]);
            {x[12], x[8], x[4], x[0]} = q;
            q = quarter(x[5], x[9], x[13], x[1]);
            {x[1], x[13], x[9], x[5]} = q;
            q = quarter(x[10], x[14], x[2], x[6]);
            {x[6], x[2], x[14], x[10]} = q;
            q = quarter(x[15], x[3], x[7], x[11]);
            {x[11], x[7], x[3], x[15]} = q;
        end
        else
        begin
            q = quarter(x[0], x[1], x[2], x[3]);
            {x[3], x[2], x[1], x[0]} = q;
            q = quarter(x[5], x[6], x[7], x[4]);
            {x[4], x[7], x[6], x[5]} = q;
            q = quarter(x[10], x[11], x[8], x[9]);
            {x[9], x[8], x[11], x[10]} = q;
            q = quarter(x[15], x[12], x[13], x[14]);
            {x[14], x[13], x[12], x[15]} = q;
        end
        for (int i = 0; i < 16; i++) o[32*i +: 32] = x[i];
        half_round = o;
    endfunction

endpackage

### src/srx_ram.sv
module srx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/srx_blockmix.sv
// BlockMix over the pairs in the work memory; the result is written back
// into the work memory. Optionally XORs a table block into the input first,
// which is done pair by pair before the mix starts.
module srx_blockmix #(
    parameter int PAW = 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  srx_pkg::bm_ctrl_t ctrl,
    input  logic [1:0]      r,
    output logic            done,
    // work memory read (registered) and write
    output logic [PAW-1:0]  wk_raddr,
    input  logic [63:0]     wk_rdata,
    output logic            wk_we,
    output logic [PAW-1:0]  wk_waddr,
    output logic [63:0]     wk_wdata,
    // table read data for the pair addressed by wk_raddr
    input  logic [63:0]     tb_rdata,
    // scratch memory
    output logic            sc_we,
    output logic [PAW-1:0]  sc_waddr,
    output logic [63:0]     sc_wdata,
    output logic [PAW-1:0]  sc_raddr,
    input  logic [63:0]     sc_rdata
);

    srx_pkg::bm_state_t st_reg, st_next;
    logic [PAW:0]   cnt_reg, cnt_next;
    logic [PAW:0]   pend_reg;
    logic           rd_vld_reg;
    logic           xt_reg;
    logic [3:0]     sub_reg, sub_next;
    logic [3:0]     rnd_reg, rnd_next;
    logic [511:0]   acc_reg;
    logic [511:0]   x_reg;
    logic [PAW:0]   pairs;
    logic [3:0]     subs;
    logic [PAW-1:0] base;
    logic [PAW-1:0] pos_base;

    assign pairs = {r, 3'b000} << 1;
    assign subs  = {1'b0, r, 1'b0};

    // Sequencing of phases: copy pass (with optional XOR), then per sub-block load, rounds,
    // add, write.
    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        sub_next = sub_reg;
        rnd_next = rnd_reg;
        unique case (st_reg)
            srx_pkg::BM_IDLE:
            begin
                cnt_next = '0;
                sub_next = '0;
                if (ctrl.start)
                begin
                    st_next = srx_pkg::BM_XOR;
                end
            end
            srx_pkg::BM_XOR:
            begin
                if (cnt_reg == pairs + 1)
                begin
                    cnt_next = '0;
                    st_next  = srx_pkg::BM_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            srx_pkg::BM_INIT:
            begin
                // XOR the current sub-block into acc (for sub 0 acc holds the last sub-block)
                if (cnt_reg == 6'd9)
                begin
                    cnt_next = '0;
                    rnd_next = '0;
                    st_next  = srx_pkg::BM_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            srx_pkg::BM_ROUND:
            begin
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == 4'd7)
                begin
                    st_next = srx_pkg::BM_ADD;
                end
            end
            srx_pkg::BM_ADD:
            begin
                cnt_next = '0;
                st_next  = srx_pkg::BM_WRITE;
            end
            srx_pkg::BM_WRITE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd7)
                begin
                    cnt_next = '0;
                    sub_next = sub_reg + 1'b1;
                    st_next  = (sub_reg + 1'b1 == subs) ? srx_pkg::BM_IDLE
                                                       : srx_pkg::BM_INIT;
                end
            end
            default:
            begin
                st_next = srx_pkg::BM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= srx_pkg::BM_IDLE;
            cnt_reg    <= '0;
            sub_reg    <= '0;
            rnd_reg    <= '0;
            rd_vld_reg <= 1'b0;
            xt_reg     <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            cnt_reg    <= cnt_next;
            sub_reg    <= sub_next;
            rnd_reg    <= rnd_next;
            rd_vld_reg <= (st_reg == srx_pkg::BM_XOR && cnt_reg < pairs)
                       || (st_reg == srx_pkg::BM_INIT && cnt_reg < 6'd8);
            if (ctrl.start && st_reg == srx_pkg::BM_IDLE)
            begin
                xt_reg <= ctrl.xor_table;
            end
        end
    end

    assign done = (st_reg == srx_pkg::BM_WRITE) && (cnt_reg == 6'd7)
               && (sub_reg + 1'b1 == subs);

    // The BlockMix input lives in the work memory during XOR, and is copied
    // to scratch so that outputs can overwrite work in place.
    assign base = PAW'({sub_reg, 3'b000});

    always_comb
    begin
        wk_raddr = '0;
        sc_raddr = '0;
        if (st_reg == srx_pkg::BM_XOR)
        begin
            wk_raddr = cnt_reg[PAW-1:0];
        end
        else if (st_reg == srx_pkg::BM_INIT)
        begin
            sc_raddr = base + PAW'(cnt_reg[2:0]);
        end
    end

    // XOR pass writes input (optionally mixed with table) into scratch.
    // Without xor_table the copy also runs through this pass.
    always_ff @(posedge clk)
    begin
        pend_reg <= cnt_reg;
    end

    assign sc_we    = rd_vld_reg && (st_reg == srx_pkg::BM_XOR);
    assign sc_waddr = pend_reg[PAW-1:0];
    assign sc_wdata = xt_reg ? (wk_rdata ^ tb_rdata) : wk_rdata;

    // Sub-block accumulation: acc starts as the last sub-block, which equals
    // the running acc from the previous step; initialized once from the copy-pass data.
    always_ff @(posedge clk)
    begin
        if (st_reg == srx_pkg::BM_IDLE)
        begin
            acc_reg <= '0;
        end
        else if (st_reg == srx_pkg::BM_XOR && rd_vld_reg
                 && pend_reg >= pairs - 6'd8)
        begin
            acc_reg[64*(pend_reg[2:0]) +: 64] <= sc_wdata;
        end
        else if (st_reg == srx_pkg::BM_INIT && rd_vld_reg)
        begin
            acc_reg[64*(pend_reg[2:0]) +: 64] <= acc_reg[64*(pend_reg[2:0]) +: 64]
                                                ^ sc_rdata;
        end
        else if (st_reg == srx_pkg::BM_INIT && cnt_reg == 6'd9)
        begin
            x_reg <= acc_reg;
        end
        else if (st_reg == srx_pkg::BM_ROUND)
        begin
            x_reg <= srx_pkg::half_round(x_reg, rnd_reg[0]);
        end
        else if (st_reg == srx_pkg::BM_ADD)
        begin
            for (int i = 0; i < 16; i++)
            begin
                acc_reg[32*i +: 32] <= acc_reg[32*i +: 32] + x_reg[32*i +: 32];
            end
        end
    end

    // Even sub-blocks go first, odd ones after.
    assign pos_base = PAW'({(sub_reg >> 1) + (sub_reg[0] ? {2'b00, r} : 4'd0), 3'b000});
    assign wk_we    = (st_reg == srx_pkg::BM_WRITE);
    assign wk_waddr = pos_base + PAW'(cnt_reg[2:0]);
    assign wk_wdata = acc_reg[64*(cnt_reg[2:0]) +: 64];

endmodule

### src/scrypt_romix_core.sv
// Channel | Dir | Beat contents
// s_axis  | in  | tdata = {word_odd, word_even}
// m_axis  | out | tdata = {out_odd, out_even}, tlast = last_out
// cfg     | in  | index 0 block_factor, 1 cost_log2
// A block of 16r pairs loads at one beat a cycle unless a register write is offered,
// then takes 2N BlockMix runs, each a start step, a copy pass over the block, and per
// sub-block a load/XOR, 8 half rounds in the single Salsa20/8 unit, an add and an
// 8-pair write-back. The 16r result beats are then read out of the work memory.
// Reset restores the sequencer and config registers; memories are not cleared.
// Input is stalled outside loading and while a register write is offered;
// output waits on m_axis_tready.
module scrypt_romix_core #(
    parameter int MAX_BLOCK_FACTOR = 2,
    parameter int MAX_COST_LOG2    = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // word_even[31:0], word_odd[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_even[31:0], out_odd[63:32]
    output logic        m_axis_tlast,   // last_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int PAW = $clog2(16 * MAX_BLOCK_FACTOR);
    localparam int TAW = PAW + MAX_COST_LOG2;

    srx_pkg::state_t st_reg, st_next;
    logic [1:0]     bf_reg;
    logic [3:0]     cl_reg;
    logic [1:0]     r;
    logic [3:0]     lg;
    logic [PAW:0]   pairs;
    logic [PAW:0]   ld_reg;
    logic [MAX_COST_LOG2:0] it_reg;
    logic [MAX_COST_LOG2:0] n_blocks;
    logic [MAX_COST_LOG2-1:0] j_reg;
    logic [PAW:0]   em_reg;
    logic           em_vld_reg;
    logic           bm_busy_reg;
    logic           bm_done;
    srx_pkg::bm_ctrl_t bm_ctrl;

    logic [PAW-1:0] wk_raddr, wk_waddr, bm_raddr, bm_waddr, sc_waddr, sc_raddr;
    logic [63:0]    wk_rdata, wk_wdata, bm_wdata, sc_wdata, sc_rdata, tb_rdata, tb_wdata;
    logic           wk_we, bm_we, sc_we, tb_we;
    logic [TAW-1:0] tb_waddr, tb_raddr;

    assign r  = (bf_reg == 2'd0) ? 2'd1
              : ({1'b0, bf_reg} > 3'(MAX_BLOCK_FACTOR)) ? 2'(MAX_BLOCK_FACTOR) : bf_reg;
    assign lg = (cl_reg > 4'(MAX_COST_LOG2)) ? 4'(MAX_COST_LOG2) : cl_reg;
    assign pairs    = (PAW+1)'({r, 4'b0000});
    assign n_blocks = (MAX_COST_LOG2+1)'(1) << lg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (st_reg == srx_pkg::ST_LOAD) && !cfg_valid;

    // Sequencer next state.
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            srx_pkg::ST_LOAD:
                if (s_axis_tvalid && ld_reg + 1'b1 >= pairs && !cfg_valid)
                    st_next = srx_pkg::ST_FILL;
            srx_pkg::ST_FILL:
                if (bm_done && it_reg + 1'b1 == n_blocks)
                    st_next = srx_pkg::ST_MIX;
            srx_pkg::ST_MIX:
                if (bm_done && it_reg + 1'b1 == n_blocks)
                    st_next = srx_pkg::ST_EMIT;
            srx_pkg::ST_EMIT:
                if (m_axis_tvalid && m_axis_tready && m_axis_tlast)
                    st_next = srx_pkg::ST_LOAD;
            default:
                st_next = srx_pkg::ST_LOAD;
        endcase
    end

    // Block-mix start requests.
    always_comb
    begin
        bm_ctrl.start     = !bm_busy_reg
                         && (st_reg == srx_pkg::ST_FILL || st_reg == srx_pkg::ST_MIX);
        bm_ctrl.xor_table = (st_reg == srx_pkg::ST_MIX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= srx_pkg::ST_LOAD;
            bf_reg      <= srx_pkg::RESET_BLOCK_FACTOR;
            cl_reg      <= srx_pkg::RESET_COST_LOG2;
            ld_reg      <= '0;
            it_reg      <= '0;
            bm_busy_reg <= 1'b0;
            em_reg      <= '0;
            em_vld_reg  <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_valid)
            begin
                ld_reg <= '0;
                if (cfg_index == srx_pkg::CFG_BLOCK_FACTOR) bf_reg <= cfg_data[1:0];
                else cl_reg <= cfg_data;
            end
            else if (s_axis_tvalid && s_axis_tready)
            begin
                ld_reg <= (ld_reg + 1'b1 >= pairs) ? '0 : ld_reg + 1'b1;
            end
            if (bm_ctrl.start) bm_busy_reg <= 1'b1;
            else if (bm_done) bm_busy_reg <= 1'b0;
            if (st_reg != st_next) it_reg <= '0;
            else if (bm_done) it_reg <= it_reg + 1'b1;
            // emit: read address runs one ahead of the registered data
            if (st_reg != srx_pkg::ST_EMIT)
            begin
                em_reg     <= '0;
                em_vld_reg <= 1'b0;
            end
            else if (!em_vld_reg || m_axis_tready)
            begin
                em_vld_reg <= (em_reg < pairs) && !(em_vld_reg && m_axis_tlast);
                em_reg     <= em_reg + 1'b1;
            end
        end
    end

    // Index for the mixing step: low word of pair 16r-8, taken from the mix output.
    always_ff @(posedge clk)
    begin
        if (bm_we && bm_waddr == PAW'(pairs - 8))
            j_reg <= bm_wdata[MAX_COST_LOG2-1:0];
    end

    // Table writes during fill mirror the copy pass into scratch.
    assign tb_we    = (st_reg == srx_pkg::ST_FILL) && sc_we;
    assign tb_waddr = {it_reg[MAX_COST_LOG2-1:0], sc_waddr};
    assign tb_wdata = sc_wdata;
    assign tb_raddr = {j_reg & MAX_COST_LOG2'(n_blocks - 1), wk_raddr};

    // Work memory: loads, block-mix writes and emit reads share it.
    // While the output stalls, the read address falls back to the pair on display.
    assign wk_we    = (s_axis_tvalid && s_axis_tready && !cfg_valid) || bm_we;
    assign wk_waddr = (st_reg == srx_pkg::ST_LOAD) ? ld_reg[PAW-1:0] : bm_waddr;
    assign wk_wdata = (st_reg == srx_pkg::ST_LOAD) ? s_axis_tdata : bm_wdata;
    assign wk_raddr = (st_reg != srx_pkg::ST_EMIT) ? bm_raddr
                    : (!em_vld_reg || m_axis_tready) ? em_reg[PAW-1:0]
                    : em_reg[PAW-1:0] - 1'b1;

    srx_ram #(.WIDTH(64), .DEPTH(1 << PAW)) u_work (
        .clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
        .raddr(wk_raddr), .rdata(wk_rdata));

    srx_ram #(.WIDTH(64), .DEPTH(1 << PAW)) u_scratch (
        .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
        .raddr(sc_raddr), .rdata(sc_rdata));

    srx_ram #(.WIDTH(64), .DEPTH(1 << TAW)) u_table (
        .clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
        .raddr(tb_raddr), .rdata(tb_rdata));

    srx_blockmix #(.PAW(PAW)) u_bm (
        .clk(clk), .rst_n(rst_n), .ctrl(bm_ctrl), .r(r), .done(bm_done),
        .wk_raddr(bm_raddr), .wk_rdata(wk_rdata), .wk_we(bm_we), .wk_waddr(bm_waddr),
        .wk_wdata(bm_wdata), .tb_rdata(tb_rdata), .sc_we(sc_we), .sc_waddr(sc_waddr),
        .sc_wdata(sc_wdata), .sc_raddr(sc_raddr), .sc_rdata(sc_rdata));

    assign m_axis_tvalid = em_vld_reg;
    assign m_axis_tdata  = wk_rdata;
    assign m_axis_tlast  = em_vld_reg && (em_reg == pairs);

    // Input is only taken while loading.
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != srx_pkg::ST_LOAD) |-> !s_axis_tready)
        else $error("input accepted during a pass");

    // Output only during emission.
    a_out_emit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (st_reg == srx_pkg::ST_EMIT))
        else $error("output outside emission");

    // The block-mix unit never finishes without having been started.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bm_done |-> bm_busy_reg)
        else $error("block mix done while idle");

endmodule
